// ===== src/sqs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack/queue store package
// Item types, operation and status codes, and the control and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sqs_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_PALL = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_POP  = 2'd3;

  // Status codes carried by a result item.
  localparam logic [1:0] ST_VALUE      = 2'd0;
  localparam logic [1:0] ST_PEEK_EMPTY = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd2;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd3;

  // Input item.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] push_value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       peek;
    logic       err;
    logic [1:0] err_code;
    logic       pall_start;
    logic       pall_emit;
  } sqs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic last_one;
    logic slot_free;
  } sqs_status_t;

endpackage

// ===== src/sqs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack/queue store controller
// Decodes accepted items into datapath commands and sequences the print-all
// walk, one entry per cycle while the output slot can take it.
// ----------------------------------------------------------------------------
module sqs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          op,
  output logic                in_stall,
  input  sqs_pkg::sqs_status_t stat,
  output sqs_pkg::sqs_cmd_t   cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PALL = 1'b1;

  logic state;
  logic state_next;
  logic needs_slot;
  logic accept;

  // An item needs the output slot if it produces a result at once.
  always_comb begin
    case (op)
      sqs_pkg::OP_PUSH: needs_slot = stat.full;
      sqs_pkg::OP_PALL: needs_slot = 1'b0;
      sqs_pkg::OP_PEEK: needs_slot = 1'b1;
      sqs_pkg::OP_POP:  needs_slot = stat.empty;
      default:          needs_slot = 1'b1;
    endcase
  end

  assign in_stall = (state != ST_IDLE) || (needs_slot && !stat.slot_free);
  assign accept   = in_valid && !in_stall;

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            sqs_pkg::OP_PUSH: begin
              if (stat.full) begin
                cmd.err      = 1'b1;
                cmd.err_code = sqs_pkg::ST_PUSH_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
            sqs_pkg::OP_PALL: begin
              if (!stat.empty) begin
                cmd.pall_start = 1'b1;
                state_next     = ST_PALL;
              end
            end
            sqs_pkg::OP_PEEK: begin
              if (stat.empty) begin
                cmd.err      = 1'b1;
                cmd.err_code = sqs_pkg::ST_PEEK_EMPTY;
              end else begin
                cmd.peek = 1'b1;
              end
            end
            sqs_pkg::OP_POP: begin
              if (stat.empty) begin
                cmd.err      = 1'b1;
                cmd.err_code = sqs_pkg::ST_POP_EMPTY;
              end else begin
                cmd.pop = 1'b1;
              end
            end
            default: begin
              cmd = '0;
            end
          endcase
        end
      end
      ST_PALL: begin
        if (stat.slot_free) begin
          cmd.pall_emit = 1'b1;
          if (stat.last_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/sqs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack/queue store datapath
// Circular entry memory with top pointer and count, the print-all read
// pointer, the mode register and the registered output slot.
// ----------------------------------------------------------------------------
module sqs_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic signed [31:0]    push_value,
  input  sqs_pkg::sqs_cmd_t     cmd,
  output sqs_pkg::sqs_status_t  stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sqs_pkg::out_item_t    out_item
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  logic signed [31:0] mem [DEPTH];

  logic [IDX_W-1:0] top;
  logic [CNT_W-1:0] count;
  logic             queue_mode;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] rem;

  logic [IDX_W-1:0] top_dec;
  logic [IDX_W-1:0] top_inc;
  logic [IDX_W-1:0] rd_inc;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] wr_addr;
  logic             at_top;
  logic             load;
  logic [IDX_W-1:0] rd_addr;

  // Wrapping pointer arithmetic around the buffer length.
  assign top_dec  = (top == '0) ? LAST_IDX : top - 1'b1;
  assign top_inc  = (top == LAST_IDX) ? '0 : top + 1'b1;
  assign rd_inc   = (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
  assign tail_sum = SUM_W'(top) + SUM_W'(count);
  assign tail_idx = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                            : IDX_W'(tail_sum);

  // A push goes in front of the top in stack mode or when empty.
  assign at_top  = !queue_mode || (count == '0);
  assign wr_addr = at_top ? top_dec : tail_idx;

  // Status towards the controller.
  assign stat.empty     = (count == '0);
  assign stat.full      = (count >= DEPTH_CNT);
  assign stat.last_one  = (rem == CNT_W'(1));
  assign stat.slot_free = !out_valid || !out_stall;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_mode <= 1'b0;
    end else if (cfg_we) begin
      queue_mode <= cfg_wdata;
    end
  end

  // Top pointer and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      top   <= '0;
      count <= '0;
    end else if (cmd.err) begin
      top   <= '0;
      count <= '0;
    end else if (cmd.push) begin
      if (at_top) begin
        top <= top_dec;
      end
      count <= count + 1'b1;
    end else if (cmd.pop) begin
      top   <= top_inc;
      count <= count - 1'b1;
    end
  end

  // Print-all walk pointer and remaining entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      rem    <= '0;
    end else if (cmd.pall_start) begin
      rd_ptr <= top;
      rem    <= count;
    end else if (cmd.pall_emit) begin
      rd_ptr <= rd_inc;
      rem    <= rem - 1'b1;
    end
  end

  // Entry memory write port.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= push_value;
    end
  end

  assign load    = cmd.peek || cmd.err || cmd.pall_emit;
  assign rd_addr = cmd.peek ? top : rd_ptr;

  // Output slot: the registered memory read doubles as the result register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_item.data   <= cmd.err ? 32'sd0 : mem[rd_addr];
      out_item.status <= cmd.err ? cmd.err_code : sqs_pkg::ST_VALUE;
      out_item.last   <= cmd.pall_emit ? stat.last_one : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/stack_queue_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack/queue store
// Bounded store of signed 32-bit entries working as a stack or a queue.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_valid/in_stall/in_item with an operation code and a
// push value. Results leave on out_valid/out_stall/out_item, each carrying
// a data word, a status code and a last flag on the final result of an item.
// cfg_we/cfg_wdata set the mode: 0 pushes at the top, 1 appends at the
// bottom. Write it only while the block is idle.
// A push or a pop that succeeds produces no result. A peek's result appears in
// the output register on the next cycle. An error gives one result with zero
// data and empties the store.
// Print-all first loads the walk pointer and count, then reads one entry per
// cycle from the entry memory's single read port while the output register
// can take it; input is stalled meanwhile.
// A push or a pop that succeeds is taken even while a result waits; items
// that need the output register are stalled until it frees.
// Reset clears the count, top pointer, mode and output valid; the entry
// memory is not cleared and needs no clearing pass.
// A stalled receiver holds the result and, in turn, stalls the items that need it.
// ----------------------------------------------------------------------------
module stack_queue_store #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  sqs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sqs_pkg::out_item_t out_item
);

  sqs_pkg::sqs_cmd_t    cmd;
  sqs_pkg::sqs_status_t stat;

  // Controller.
  sqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (in_item.op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  sqs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push_value (in_item.push_value),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// ===== src/sqs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack/queue store checker
// Port-level properties of the store, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sqs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input sqs_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input sqs_pkg::out_item_t out_item
);

  // The output register is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // While a print-all is unfinished, no new item is taken.
  a_pall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last |-> in_stall)
    else $error("input taken during print-all");

  // An error result carries zero data and ends its item.
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status != sqs_pkg::ST_VALUE)
      |-> (out_item.data == 32'sd0) && out_item.last)
    else $error("malformed error result");

  // An accepted peek always gives a result on the next cycle.
  a_peek_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_item.op == sqs_pkg::OP_PEEK) |=> out_valid)
    else $error("peek gave no result");

endmodule

bind stack_queue_store sqs_checker u_sqs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack/queue store testbench
// Sends push, pop, peek and print-all items to the store in stack and queue
// modes. A shadow copy of the store works out the results that each accepted
// item should give, and every result item is compared in order. Directed
// items cover empty-store errors, value extremes and mode behaviour. Random
// traffic then fills the store past full, with idling on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int DEPTH       = 64;
  localparam int MAX_CYCLES  = 400000;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic               cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  sqs_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sqs_pkg::out_item_t out_item;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int error_count    = 0;

  // Shadow copy of the store and its mode.
  logic signed [31:0] shadow_vals [DEPTH];
  int                 shadow_top   = 0;
  int                 shadow_count = 0;
  logic               shadow_queue_mode = 1'b0;

  // Result items still owed by the store, oldest first.
  sqs_pkg::out_item_t results_due [$];

  stack_queue_store #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Clock.
  always #2 clk = ~clk;

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // An error result empties the shadow store.
  task automatic shadow_error(input logic [1:0] code);
    sqs_pkg::out_item_t r;
    r.data   = '0;
    r.status = code;
    r.last   = 1'b1;
    results_due.push_back(r);
    shadow_count = 0;
    shadow_top   = 0;
  endtask

  // Apply one accepted item to the shadow store and queue its results.
  task automatic shadow_apply(input sqs_pkg::in_item_t it);
    sqs_pkg::out_item_t r;
    case (it.op)
      sqs_pkg::OP_PUSH: begin
        if (shadow_count >= DEPTH) begin
          shadow_error(sqs_pkg::ST_PUSH_FULL);
        end else begin
          if (!shadow_queue_mode || shadow_count == 0) begin
            shadow_top = (shadow_top + DEPTH - 1) % DEPTH;
            shadow_vals[shadow_top] = it.push_value;
          end else begin
            shadow_vals[(shadow_top + shadow_count) % DEPTH] = it.push_value;
          end
          shadow_count++;
        end
      end
      sqs_pkg::OP_PALL: begin
        for (int i = 0; i < shadow_count; i++) begin
          r.data   = shadow_vals[(shadow_top + i) % DEPTH];
          r.status = sqs_pkg::ST_VALUE;
          r.last   = (i == shadow_count - 1);
          results_due.push_back(r);
        end
      end
      sqs_pkg::OP_PEEK: begin
        if (shadow_count == 0) begin
          shadow_error(sqs_pkg::ST_PEEK_EMPTY);
        end else begin
          r.data   = shadow_vals[shadow_top];
          r.status = sqs_pkg::ST_VALUE;
          r.last   = 1'b1;
          results_due.push_back(r);
        end
      end
      default: begin
        if (shadow_count == 0) begin
          shadow_error(sqs_pkg::ST_POP_EMPTY);
        end else begin
          shadow_top = (shadow_top + 1) % DEPTH;
          shadow_count--;
        end
      end
    endcase
  endtask

  // Compare each accepted result item with the oldest one owed.
  always @(posedge clk) begin
    sqs_pkg::out_item_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (results_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, got data %0d status %0d last %0d",
                 $time, out_item.data, out_item.status, out_item.last);
      end else begin
        want = results_due.pop_front();
        if (out_item !== want) begin
          error_count++;
          $display({"%0t: result mismatch: expected data %0d status %0d last %0d, ",
                    "got data %0d status %0d last %0d"},
                   $time, want.data, want.status, want.last,
                   out_item.data, out_item.status, out_item.last);
        end
      end
    end
  end

  // Send one item, idling at random first; entered and left at a falling edge.
  task automatic send_item(input logic [1:0] op, input logic [31:0] value);
    sqs_pkg::in_item_t it;
    it.op         = op;
    it.push_value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow_apply(it);
    @(negedge clk);
  endtask

  // Stop sending and wait until the store owes nothing more.
  task automatic wait_store_idle(input int settle);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Mode writes happen only with the store idle.
  task automatic write_mode(input logic mode);
    wait_store_idle(4);
    cfg_wdata <= mode;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_queue_mode = mode;
    @(negedge clk);
  endtask

  // Push values lean towards the extremes of the signed range.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Stack mode: errors on an empty store, extremes and every operation.
  task automatic test_stack_basics();
    write_mode(1'b0);
    send_item(sqs_pkg::OP_PEEK, $urandom());
    send_item(sqs_pkg::OP_POP, $urandom());
    send_item(sqs_pkg::OP_PALL, $urandom());
    send_item(sqs_pkg::OP_PUSH, 32'h7fff_ffff);
    send_item(sqs_pkg::OP_PUSH, 32'h8000_0000);
    send_item(sqs_pkg::OP_PUSH, 32'h0000_0000);
    send_item(sqs_pkg::OP_PUSH, 32'hffff_ffff);
    send_item(sqs_pkg::OP_PEEK, $urandom());
    send_item(sqs_pkg::OP_PALL, $urandom());
    send_item(sqs_pkg::OP_POP, $urandom());
    send_item(sqs_pkg::OP_PEEK, $urandom());
    send_item(sqs_pkg::OP_POP, $urandom());
    send_item(sqs_pkg::OP_POP, $urandom());
    send_item(sqs_pkg::OP_POP, $urandom());
    send_item(sqs_pkg::OP_POP, $urandom());
  endtask

  // Queue mode: the first push on an empty store becomes the top.
  task automatic test_queue_basics();
    write_mode(1'b1);
    send_item(sqs_pkg::OP_PUSH, 32'd5);
    send_item(sqs_pkg::OP_PUSH, 32'h5555_5555);
    send_item(sqs_pkg::OP_PUSH, 32'haaaa_aaaa);
    send_item(sqs_pkg::OP_PALL, $urandom());
    send_item(sqs_pkg::OP_PEEK, $urandom());
    send_item(sqs_pkg::OP_POP, $urandom());
    send_item(sqs_pkg::OP_PEEK, $urandom());
    send_item(sqs_pkg::OP_PALL, $urandom());
  endtask

  // Mostly well-formed traffic with a share of any operation.
  task automatic run_random_ops(input int count);
    int         r;
    logic [1:0] op;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40)      op = sqs_pkg::OP_PUSH;
      else if (r < 62) op = sqs_pkg::OP_POP;
      else if (r < 80) op = sqs_pkg::OP_PEEK;
      else if (r < 90) op = sqs_pkg::OP_PALL;
      else             op = 2'($urandom_range(3));
      send_item(op, pick_value());
    end
  endtask

  // Fill the store, list it in full, push once more to overflow it, then peek it.
  task automatic fill_to_overflow();
    while (shadow_count < DEPTH) send_item(sqs_pkg::OP_PUSH, pick_value());
    send_item(sqs_pkg::OP_PALL, $urandom());
    send_item(sqs_pkg::OP_PUSH, pick_value());
    send_item(sqs_pkg::OP_PEEK, $urandom());
  endtask

  // One phase of random traffic in a given mode and idling mix.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic mode);
    write_mode(mode);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    run_random_ops(30);
    fill_to_overflow();
    // Hold new items back until every owed result has come out.
    wait_store_idle(1);
    run_random_ops(30);
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_stack_basics();
    test_queue_basics();
    test_random_traffic(29, 61, 1'b1);
    test_random_traffic(61, 29, 1'b0);
    test_random_traffic(0, 0, 1'b1);

    wait_store_idle(8);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sqs_pkg.sv
src/sqs_ctrl.sv
src/sqs_datapath.sv
src/stack_queue_store.sv
src/sqs_checker.sv
verif/tb.sv
